// ===== hw/rtl/vas_pkg.sv =====
package vas_pkg;

	localparam int EXT_W = 5;
	localparam int COORD_W = 4;
	localparam int CMP_W = 9;
	localparam int CNT_W = 13;
	localparam int FACE_W = 15;
	localparam int CFG_IDX_W = 2;
	localparam int FACES_PER_CELL = 6;

	typedef enum logic [1:0] {
		FN_LOAD    = 2'd0,
		FN_COMPUTE = 2'd1,
		FN_CLEAR   = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXTENT_X = 2'd0,
		REG_EXTENT_Y = 2'd1,
		REG_EXTENT_Z = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [COORD_W-1:0] coord_z;
		logic               add_solid;
		logic               add_active;
	} cmd_t;

	typedef struct packed {
		logic              coord_error;
		logic [CNT_W-1:0]  solid_cells;
		logic [FACE_W-1:0] surface_faces;
		logic [CNT_W-1:0]  layer_cells;
		logic [CNT_W-1:0]  adsorbed_cells;
	} res_t;

endpackage

// ===== hw/rtl/vas_if.sv =====
interface vas_item_if import vas_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;
	logic [COORD_W-1:0] coord_z;
	logic               add_solid;
	logic               add_active;

	modport source (output valid, func, coord_x, coord_y, coord_z, add_solid, add_active,
		input ready);
	modport sink (input valid, func, coord_x, coord_y, coord_z, add_solid, add_active,
		output ready);
endinterface

interface vas_result_if import vas_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              coord_error;
	logic [CNT_W-1:0]  solid_cells;
	logic [FACE_W-1:0] surface_faces;
	logic [CNT_W-1:0]  layer_cells;
	logic [CNT_W-1:0]  adsorbed_cells;

	modport source (output valid, coord_error, solid_cells, surface_faces, layer_cells,
		adsorbed_cells, input ready);
	modport sink (input valid, coord_error, solid_cells, surface_faces, layer_cells,
		adsorbed_cells, output ready);
endinterface

// ===== hw/rtl/vas_store.sv =====
module vas_store #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);

	logic [1:0] mem [DEPTH];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/vas_seq.sv =====
module vas_seq import vas_pkg::*; #(
	parameter int MAX_X = 16,
	parameter int MAX_Y = 16,
	parameter int MAX_Z = 16,
	parameter int AW = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CMP_W-1:0] ex,
	input  logic [CMP_W-1:0] ey,
	input  logic [CMP_W-1:0] ez,
	input  logic             in_valid,
	output logic             in_ready,
	input  cmd_t             cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             res,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [1:0]       mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	input  logic [1:0]       mem_rdata
);

	localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;

	typedef enum logic [6:0] {
		ST_INIT    = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_LOAD_RD = 7'b0000100,
		ST_LOAD_WR = 7'b0001000,
		ST_CLR     = 7'b0010000,
		ST_SCAN    = 7'b0100000,
		ST_DRAIN   = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		STEP_C  = 3'd0,
		STEP_XM = 3'd1,
		STEP_XP = 3'd2,
		STEP_YM = 3'd3,
		STEP_YP = 3'd4,
		STEP_ZM = 3'd5,
		STEP_ZP = 3'd6
	} step_t;

	typedef struct packed {
		logic live;
		logic center;
		logic vld;
		logic last;
	} tag_t;

	function automatic logic [AW-1:0] cell_addr(logic [XW-1:0] x, logic [YW-1:0] y,
		logic [ZW-1:0] z);
		logic [31:0] a;
		a = (32'(x) * 32'(MAX_Y) + 32'(y)) * 32'(MAX_Z) + 32'(z);
		return a[AW-1:0];
	endfunction

	state_t             state_q;
	step_t              step_q;
	cmd_t               cmd_q;
	tag_t               tag_s1;
	logic [AW-1:0]      clr_cnt_q;
	logic [XW-1:0]      cx_q;
	logic [YW-1:0]      cy_q;
	logic [ZW-1:0]      cz_q;
	logic [1:0]         cen_q;
	logic [2:0]         nb_q;
	logic               out_valid_q;
	res_t               res_q;

	logic [CMP_W-1:0]   lx, ly, lz;
	logic               load_err;
	logic [AW-1:0]      load_addr;
	logic [XW-1:0]      nx;
	logic [YW-1:0]      ny;
	logic [ZW-1:0]      nz;
	logic               nvld;
	logic               x_last, y_last, z_last;
	logic               accept;
	logic [1:0]         load_bits;
	logic               hit;
	logic [2:0]         nb_tot;

	assign lx = CMP_W'(cmd_q.coord_x);
	assign ly = CMP_W'(cmd_q.coord_y);
	assign lz = CMP_W'(cmd_q.coord_z);
	assign load_addr = cell_addr(lx[XW-1:0], ly[YW-1:0], lz[ZW-1:0]);
	assign load_bits = {cmd_q.add_active, cmd_q.add_solid};
	assign load_err = (CMP_W'(cmd.coord_x) >= ex) || (CMP_W'(cmd.coord_y) >= ey) ||
		(CMP_W'(cmd.coord_z) >= ez);

	assign x_last = (CMP_W'(cx_q) + 1'b1) >= ex;
	assign y_last = (CMP_W'(cy_q) + 1'b1) >= ey;
	assign z_last = (CMP_W'(cz_q) + 1'b1) >= ez;

	// neighbor coordinates; an absent neighbor reads the center and is ignored
	always_comb begin
		nx = cx_q;
		ny = cy_q;
		nz = cz_q;
		nvld = 1'b1;
		case (step_q)
			STEP_C: begin
				nvld = 1'b1;
			end
			STEP_XM: begin
				nvld = cx_q != '0;
				if (nvld) nx = cx_q - 1'b1;
			end
			STEP_XP: begin
				nvld = !x_last;
				if (nvld) nx = cx_q + 1'b1;
			end
			STEP_YM: begin
				nvld = cy_q != '0;
				if (nvld) ny = cy_q - 1'b1;
			end
			STEP_YP: begin
				nvld = !y_last;
				if (nvld) ny = cy_q + 1'b1;
			end
			STEP_ZM: begin
				nvld = cz_q != '0;
				if (nvld) nz = cz_q - 1'b1;
			end
			STEP_ZP: begin
				nvld = !z_last;
				if (nvld) nz = cz_q + 1'b1;
			end
			default: begin
				nvld = 1'b0;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	assign mem_raddr = (state_q == ST_SCAN) ? cell_addr(nx, ny, nz) : load_addr;
	assign mem_we = (state_q == ST_INIT) || (state_q == ST_CLR) || (state_q == ST_LOAD_WR);
	assign mem_waddr = (state_q == ST_LOAD_WR) ? load_addr : clr_cnt_q;
	assign mem_wdata = (state_q == ST_LOAD_WR) ? (mem_rdata | load_bits) : 2'b00;

	assign hit = tag_s1.vld && mem_rdata[0];
	assign nb_tot = nb_q + 3'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			step_q <= STEP_C;
			tag_s1 <= '0;
			clr_cnt_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) out_valid_q <= 1'b0;
			tag_s1 <= '0;
			case (state_q)
				ST_INIT, ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						clr_cnt_q <= '0;
						state_q <= ST_IDLE;
						if (state_q == ST_CLR) out_valid_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd.func)
							FN_LOAD: begin
								if (load_err) out_valid_q <= 1'b1;
								else state_q <= ST_LOAD_RD;
							end
							FN_COMPUTE: begin
								step_q <= STEP_C;
								cx_q <= '0;
								cy_q <= '0;
								cz_q <= '0;
								state_q <= ST_SCAN;
							end
							FN_CLEAR: begin
								clr_cnt_q <= '0;
								state_q <= ST_CLR;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_LOAD_RD: begin
					state_q <= ST_LOAD_WR;
				end
				ST_LOAD_WR: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					tag_s1 <= '{live: 1'b1, center: step_q == STEP_C, vld: nvld,
						last: step_q == STEP_ZP};
					if (step_q == STEP_ZP) begin
						step_q <= STEP_C;
						if (!z_last) begin
							cz_q <= cz_q + 1'b1;
						end else begin
							cz_q <= '0;
							if (!y_last) begin
								cy_q <= cy_q + 1'b1;
							end else begin
								cy_q <= '0;
								if (!x_last) cx_q <= cx_q + 1'b1;
								else state_q <= ST_DRAIN;
							end
						end
					end else begin
						step_q <= step_t'(step_q + 3'd1);
					end
				end
				ST_DRAIN: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result registers double as the scan accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			res_q <= '0;
			res_q.coord_error <= (cmd.func == FN_LOAD) && load_err;
		end
		if (tag_s1.live) begin
			if (tag_s1.center) begin
				cen_q <= mem_rdata;
				nb_q <= '0;
			end else if (tag_s1.last) begin
				if (cen_q[0]) begin
					res_q.solid_cells <= res_q.solid_cells + 1'b1;
					res_q.surface_faces <= res_q.surface_faces +
						FACE_W'(3'(FACES_PER_CELL) - nb_tot);
				end else if (nb_tot != '0) begin
					res_q.layer_cells <= res_q.layer_cells + 1'b1;
				end
				if (cen_q[1] && nb_tot != '0) begin
					res_q.adsorbed_cells <= res_q.adsorbed_cells + 1'b1;
				end
			end else begin
				nb_q <= nb_tot;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

// ===== hw/rtl/voxel_adjacency_statistics_core.sv =====
// channel  role  transaction
// item     sink  func, coord_x, coord_y, coord_z, add_solid, add_active
// result   src   coord_error, solid_cells, surface_faces, layer_cells, adsorbed_cells
// cfg      write cfg_we, cfg_index, cfg_data (extent_x, extent_y, extent_z)
//
// load: read, or-in, write through the cell store; a bad coord gives an error result without a store access
// compute: one store read per neighbor or center, for every cell inside the extents
// clear: every cell of the MAX_X * MAX_Y * MAX_Z store is zeroed, one cell written per cycle
// after reset the same clearing pass runs before the first item is taken
// item ready drops while a transaction is worked on or an untaken result blocks
module voxel_adjacency_statistics_core import vas_pkg::*; #(
	parameter int MAX_X = 16,
	parameter int MAX_Y = 16,
	parameter int MAX_Z = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	vas_item_if.sink             item,
	vas_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EXT_W-1:0]     cfg_data
);

	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [EXT_W-1:0] ext_x_q, ext_y_q, ext_z_q;
	logic [CMP_W-1:0] ex, ey, ez;
	cmd_t             cmd;
	res_t             res;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [1:0]       mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q <= EXT_W'(1);
			ext_y_q <= EXT_W'(1);
			ext_z_q <= EXT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXTENT_X: ext_x_q <= cfg_data;
				REG_EXTENT_Y: ext_y_q <= cfg_data;
				REG_EXTENT_Z: ext_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// zero counts as one, anything past the grid counts as the grid size
	assign ex = (ext_x_q == '0) ? CMP_W'(1) :
		(CMP_W'(ext_x_q) > CMP_W'(MAX_X)) ? CMP_W'(MAX_X) : CMP_W'(ext_x_q);
	assign ey = (ext_y_q == '0) ? CMP_W'(1) :
		(CMP_W'(ext_y_q) > CMP_W'(MAX_Y)) ? CMP_W'(MAX_Y) : CMP_W'(ext_y_q);
	assign ez = (ext_z_q == '0) ? CMP_W'(1) :
		(CMP_W'(ext_z_q) > CMP_W'(MAX_Z)) ? CMP_W'(MAX_Z) : CMP_W'(ext_z_q);

	assign cmd = '{func: item.func, coord_x: item.coord_x, coord_y: item.coord_y,
		coord_z: item.coord_z, add_solid: item.add_solid, add_active: item.add_active};

	vas_seq #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .AW(AW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ex        (ex),
		.ey        (ey),
		.ez        (ez),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.cmd       (cmd),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	vas_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign result.coord_error = res.coord_error;
	assign result.solid_cells = res.solid_cells;
	assign result.surface_faces = res.surface_faces;
	assign result.layer_cells = res.layer_cells;
	assign result.adsorbed_cells = res.adsorbed_cells;

endmodule

// ===== hw/rtl/vas_checker.sv =====
module vas_checker import vas_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        in_func,
	input logic              out_valid,
	input logic              out_ready,
	input logic              out_err,
	input logic [CNT_W-1:0]  out_solid,
	input logic [FACE_W-1:0] out_faces,
	input logic [CNT_W-1:0]  out_layer,
	input logic [CNT_W-1:0]  out_ads
);

	// a stalled result holds its error flag and face count
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_faces) && $stable(out_err))
		else $error("stalled result changed");

	// no new transaction while an untaken result waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || out_ready)
		else $error("item taken over a waiting result");

	// a scan keeps the block busy once taken: item ready and result valid both stay low
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func == FN_COMPUTE |=> !in_ready && !out_valid)
		else $error("compute finished too early");

	// a clear result only shows after the sweep
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_func == FN_CLEAR |=> !out_valid)
		else $error("clear result too early");

	// an error result carries no counts
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_err |-> out_solid == '0 && out_faces == '0 &&
			out_layer == '0 && out_ads == '0)
		else $error("error result with counts");

endmodule

bind voxel_adjacency_statistics_core vas_checker u_vas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_func   (item.func),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_err   (result.coord_error),
	.out_solid (result.solid_cells),
	.out_faces (result.surface_faces),
	.out_layer (result.layer_cells),
	.out_ads   (result.adsorbed_cells)
);

// ===== bench/voxel_adjacency_statistics_core_tb.sv =====
module voxel_adjacency_statistics_core_tb;
	import vas_pkg::*;

	localparam int GRID = 16;

	typedef struct {
		int   ext;     // nonzero: write all three extents to this value first
		cmd_t cmd;
		bit   pinned;  // expected result typed in below
		res_t want;
	} row_t;

	typedef struct {
		int ex, ey, ez;
		int compute_pct;
		int count;
	} phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [EXT_W-1:0] cfg_data;

	vas_item_if item ();
	vas_result_if result ();

	voxel_adjacency_statistics_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [1:0] grid_bits [GRID][GRID][GRID];
	logic [EXT_W-1:0] ext_reg [3];

	res_t counts_q [$];
	bit pin_use_q [$];
	res_t pin_val_q [$];
	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int computes_seen = 0;
	bit calm = 0;

	function automatic int clamp_ext(logic [EXT_W-1:0] v);
		if (v < 1) return 1;
		if (v > GRID) return GRID;
		return int'(v);
	endfunction

	function automatic bit solid_at(int x, int y, int z);
		return grid_bits[x][y][z][0];
	endfunction

	function automatic res_t predict_counts(cmd_t c);
		res_t r;
		int ex, ey, ez, nb;
		ex = clamp_ext(ext_reg[REG_EXTENT_X]);
		ey = clamp_ext(ext_reg[REG_EXTENT_Y]);
		ez = clamp_ext(ext_reg[REG_EXTENT_Z]);
		r = '0;
		case (c.func)
			FN_LOAD: begin
				if (c.coord_x >= ex || c.coord_y >= ey || c.coord_z >= ez)
					r.coord_error = 1'b1;
				else
					grid_bits[c.coord_x][c.coord_y][c.coord_z] |= {c.add_active, c.add_solid};
			end
			FN_COMPUTE: begin
				for (int x = 0; x < ex; x++)
					for (int y = 0; y < ey; y++)
						for (int z = 0; z < ez; z++) begin
							nb = 0;
							if (x > 0 && solid_at(x-1, y, z)) nb++;
							if (x+1 < ex && solid_at(x+1, y, z)) nb++;
							if (y > 0 && solid_at(x, y-1, z)) nb++;
							if (y+1 < ey && solid_at(x, y+1, z)) nb++;
							if (z > 0 && solid_at(x, y, z-1)) nb++;
							if (z+1 < ez && solid_at(x, y, z+1)) nb++;
							if (grid_bits[x][y][z][0]) begin
								r.solid_cells++;
								r.surface_faces += FACE_W'(FACES_PER_CELL - nb);
							end else if (nb != 0) begin
								r.layer_cells++;
							end
							if (grid_bits[x][y][z][1] && nb != 0) r.adsorbed_cells++;
						end
			end
			FN_CLEAR: begin
				foreach (grid_bits[i, j, k]) grid_bits[i][j][k] = 2'b00;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int rand_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 6_000_000);
		$display("Test completed with failures");
		$finish;
	end

	// receiver stalls
	always @(negedge clk) begin
		if (calm || $urandom_range(0, 99) < 65)
			result.ready <= 1'b1;
		else if ($urandom_range(0, 19) == 0)
			result.ready <= 1'b0;
		else
			result.ready <= 1'($urandom_range(0, 1));
	end

	always @(posedge clk) begin
		res_t got, exp_r, pred;
		bit use_pin;
		if (item.valid && item.ready) begin
			pred = predict_counts('{item.func, item.coord_x, item.coord_y, item.coord_z,
				item.add_solid, item.add_active});
			use_pin = 0;
			if (pin_use_q.size() > 0) begin
				use_pin = pin_use_q.pop_front();
				exp_r = pin_val_q.pop_front();
			end
			counts_q.insert(counts_q.size(), use_pin ? exp_r : pred);
			if (item.func == FN_COMPUTE) computes_seen++;
		end
		if (result.valid && result.ready) begin
			got = '{result.coord_error, result.solid_cells, result.surface_faces,
				result.layer_cells, result.adsorbed_cells};
			results_seen++;
			if (counts_q.size() == 0) begin
				$display("%0t: result with nothing expected: %p", $time, got);
				fail_count++;
			end else begin
				exp_r = counts_q.pop_front();
				if (got.coord_error !== exp_r.coord_error) begin
					$display("%0t: coord_error expected %0d actual %0d", $time,
						exp_r.coord_error, got.coord_error);
					fail_count++;
				end
				if (got.solid_cells !== exp_r.solid_cells) begin
					$display("%0t: solid_cells expected %0d actual %0d", $time,
						exp_r.solid_cells, got.solid_cells);
					fail_count++;
				end
				if (got.surface_faces !== exp_r.surface_faces) begin
					$display("%0t: surface_faces expected %0d actual %0d", $time,
						exp_r.surface_faces, got.surface_faces);
					fail_count++;
				end
				if (got.layer_cells !== exp_r.layer_cells) begin
					$display("%0t: layer_cells expected %0d actual %0d", $time,
						exp_r.layer_cells, got.layer_cells);
					fail_count++;
				end
				if (got.adsorbed_cells !== exp_r.adsorbed_cells) begin
					$display("%0t: adsorbed_cells expected %0d actual %0d", $time,
						exp_r.adsorbed_cells, got.adsorbed_cells);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(cmd_t c);
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			@(negedge clk);
			item.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item.valid <= 1'b1;
		{item.func, item.coord_x, item.coord_y, item.coord_z, item.add_solid,
			item.add_active} <= c;
		do @(posedge clk); while (!item.ready);
		items_sent++;
		if ($urandom_range(0, 49) == 0) calm = ~calm;
	endtask

	task automatic drain();
		@(negedge clk);
		item.valid <= 1'b0;
		while (counts_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[EXT_W-1:0];
		ext_reg[idx] = val[EXT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_extents(int ex, int ey, int ez);
		drain();
		write_reg(REG_EXTENT_X, ex);
		write_reg(REG_EXTENT_Y, ey);
		write_reg(REG_EXTENT_Z, ez);
	endtask

	function automatic cmd_t random_cmd(int compute_pct);
		cmd_t c;
		int r;
		c.add_solid = 1'($urandom_range(0, 1));
		c.add_active = 1'($urandom_range(0, 1));
		c.coord_x = 4'($urandom_range(0, 15));
		c.coord_y = 4'($urandom_range(0, 15));
		c.coord_z = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 2) c.func = FN_CLEAR;
		else if (r < 4) c.func = 2'd3;
		else if (r < 4 + compute_pct) c.func = FN_COMPUTE;
		else c.func = FN_LOAD;
		// mostly in-region loads so the grid fills up
		if ($urandom_range(0, 99) < 85) begin
			c.coord_x = 4'($urandom_range(0, clamp_ext(ext_reg[REG_EXTENT_X]) - 1));
			c.coord_y = 4'($urandom_range(0, clamp_ext(ext_reg[REG_EXTENT_Y]) - 1));
			c.coord_z = 4'($urandom_range(0, clamp_ext(ext_reg[REG_EXTENT_Z]) - 1));
		end
		return c;
	endfunction

	row_t dir_rows [] = '{
		'{0, '{FN_COMPUTE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 1, '0},
		'{0, '{FN_LOAD, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0}, 1, '0},
		'{0, '{FN_LOAD, 4'd1, 4'd0, 4'd0, 1'b1, 1'b1}, 1, '{1'b1, 13'd0, 15'd0, 13'd0, 13'd0}},
		'{0, '{FN_LOAD, 4'd0, 4'd15, 4'd0, 1'b1, 1'b1}, 1, '{1'b1, 13'd0, 15'd0, 13'd0, 13'd0}},
		'{0, '{FN_LOAD, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0}, 1,
			'{1'b1, 13'd0, 15'd0, 13'd0, 13'd0}},
		'{0, '{FN_COMPUTE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 1, '{1'b0, 13'd1, 15'd6, 13'd0, 13'd0}},
		'{0, '{FN_LOAD, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 1, '0},
		'{0, '{2'd3, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1}, 1, '0},
		'{0, '{FN_LOAD, 4'd0, 4'd0, 4'd0, 1'b0, 1'b1}, 1, '0},
		'{0, '{FN_COMPUTE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 1, '{1'b0, 13'd1, 15'd6, 13'd0, 13'd0}},
		'{0, '{FN_CLEAR, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 1, '0},
		'{0, '{FN_COMPUTE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 1, '0},
		'{2, '{FN_LOAD, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0}, 0, '0},
		'{0, '{FN_LOAD, 4'd1, 4'd0, 4'd0, 1'b1, 1'b1}, 0, '0},
		'{0, '{FN_LOAD, 4'd0, 4'd1, 4'd0, 1'b0, 1'b1}, 0, '0},
		'{0, '{FN_LOAD, 4'd1, 4'd1, 4'd1, 1'b0, 1'b1}, 0, '0},
		'{0, '{FN_LOAD, 4'd2, 4'd0, 4'd0, 1'b1, 1'b0}, 1, '{1'b1, 13'd0, 15'd0, 13'd0, 13'd0}},
		'{0, '{FN_COMPUTE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 0, '0},
		'{0, '{FN_COMPUTE, 4'd9, 4'd6, 4'd3, 1'b1, 1'b1}, 0, '0},
		'{0, '{2'd3, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0}, 0, '0}
	};

	// extents 0 and above 16 exercise the clamping; 16x16x16 gets a single scan
	phase_t phases [] = '{
		'{3, 3, 3, 12, 150},
		'{4, 2, 5, 12, 150},
		'{0, 31, 2, 12, 120},
		'{5, 5, 5, 8, 150},
		'{2, 4, 1, 12, 150},
		'{16, 1, 1, 12, 110},
		'{16, 16, 16, 0, 40},
		'{1, 16, 3, 12, 140}
	};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_EXTENT_X;
		cfg_data = '0;
		item.valid = 1'b0;
		{item.func, item.coord_x, item.coord_y, item.coord_z, item.add_solid,
			item.add_active} = '0;
		result.ready = 1'b0;
		foreach (grid_bits[i, j, k]) grid_bits[i][j][k] = 2'b00;
		foreach (ext_reg[i]) ext_reg[i] = 5'd1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].ext != 0) set_extents(dir_rows[i].ext, dir_rows[i].ext,
				dir_rows[i].ext);
			pin_use_q.insert(pin_use_q.size(), dir_rows[i].pinned);
			pin_val_q.insert(pin_val_q.size(), dir_rows[i].want);
			send_item(dir_rows[i].cmd);
		end

		foreach (phases[p]) begin
			set_extents(phases[p].ex, phases[p].ey, phases[p].ez);
			for (int n = 0; n < phases[p].count; n++)
				send_item(random_cmd(phases[p].compute_pct));
			if (phases[p].compute_pct == 0)
				send_item('{FN_COMPUTE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0});
		end

		drain();
		repeat (50) @(posedge clk);
		$display("ran %0d transactions (%0d scans) over %0d extent settings, %0d results checked",
			items_sent, computes_seen, phases.size() + 2, results_seen);
		if (fail_count == 0 && counts_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
